// File: src/cso_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the circle / segment overlap test pipeline.
// No dependencies.
package cso_pkg;

    // query kind carried on s_tuser
    localparam logic REQ_CIRCLE  = 1'b0;
    localparam logic REQ_SEGMENT = 1'b1;

    localparam int RADIUS_WIDTH = 15;
    localparam int RSUM_WIDTH   = RADIUS_WIDTH + 1;   // radius_a + radius_b
    localparam int RSQ_WIDTH    = 2 * RSUM_WIDTH;     // (radius_a + radius_b)^2

    // result word layout
    localparam int OUT_TDATA_WIDTH = 8;
    localparam int HIT_BIT         = 0;
    localparam int PAR_BIT         = 1;

endpackage

// File: src/cso_diff.sv
`timescale 1ns / 1ps
// Stage 1: edge vectors of both segments, centre offset and radius sum.
// Depends on cso_pkg.
module cso_diff #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_req,
    input  logic signed [COORD_WIDTH-1:0]         p0_x,
    input  logic signed [COORD_WIDTH-1:0]         p0_y,
    input  logic signed [COORD_WIDTH-1:0]         p1_x,
    input  logic signed [COORD_WIDTH-1:0]         p1_y,
    input  logic signed [COORD_WIDTH-1:0]         q0_x,
    input  logic signed [COORD_WIDTH-1:0]         q0_y,
    input  logic signed [COORD_WIDTH-1:0]         q1_x,
    input  logic signed [COORD_WIDTH-1:0]         q1_y,
    input  logic [cso_pkg::RADIUS_WIDTH-1:0]      radius_a,
    input  logic [cso_pkg::RADIUS_WIDTH-1:0]      radius_b,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_req,
    output logic signed [COORD_WIDTH:0]           ax,
    output logic signed [COORD_WIDTH:0]           ay,
    output logic signed [COORD_WIDTH:0]           bx,
    output logic signed [COORD_WIDTH:0]           by,
    output logic signed [COORD_WIDTH:0]           cx,
    output logic signed [COORD_WIDTH:0]           cy,
    output logic [cso_pkg::RSUM_WIDTH-1:0]        rsum
);

    localparam int DW = COORD_WIDTH + 1;

    logic                             valid_reg;
    logic                             req_reg;
    logic signed [DW-1:0]             ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [cso_pkg::RSUM_WIDTH-1:0]   rsum_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            req_reg  <= in_req;
            ax_reg   <= {p1_x[COORD_WIDTH-1], p1_x} - {p0_x[COORD_WIDTH-1], p0_x};
            ay_reg   <= {p1_y[COORD_WIDTH-1], p1_y} - {p0_y[COORD_WIDTH-1], p0_y};
            bx_reg   <= {q0_x[COORD_WIDTH-1], q0_x} - {q1_x[COORD_WIDTH-1], q1_x};
            by_reg   <= {q0_y[COORD_WIDTH-1], q0_y} - {q1_y[COORD_WIDTH-1], q1_y};
            cx_reg   <= {q0_x[COORD_WIDTH-1], q0_x} - {p0_x[COORD_WIDTH-1], p0_x};
            cy_reg   <= {q0_y[COORD_WIDTH-1], q0_y} - {p0_y[COORD_WIDTH-1], p0_y};
            rsum_reg <= {1'b0, radius_a} + {1'b0, radius_b};
        end
    end

    assign out_valid = valid_reg;
    assign out_req   = req_reg;
    assign ax        = ax_reg;
    assign ay        = ay_reg;
    assign bx        = bx_reg;
    assign by        = by_reg;
    assign cx        = cx_reg;
    assign cy        = cy_reg;
    assign rsum      = rsum_reg;

endmodule

// File: src/cso_mul.sv
`timescale 1ns / 1ps
// Stage 2: the nine cross and square products, one multiplier each.
// Depends on cso_pkg.
module cso_mul #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_req,
    input  logic signed [COORD_WIDTH:0]           ax,
    input  logic signed [COORD_WIDTH:0]           ay,
    input  logic signed [COORD_WIDTH:0]           bx,
    input  logic signed [COORD_WIDTH:0]           by,
    input  logic signed [COORD_WIDTH:0]           cx,
    input  logic signed [COORD_WIDTH:0]           cy,
    input  logic [cso_pkg::RSUM_WIDTH-1:0]        rsum,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_req,
    output logic signed [2*COORD_WIDTH+1:0]       ay_bx,
    output logic signed [2*COORD_WIDTH+1:0]       by_ax,
    output logic signed [2*COORD_WIDTH+1:0]       ay_cx,
    output logic signed [2*COORD_WIDTH+1:0]       cy_ax,
    output logic signed [2*COORD_WIDTH+1:0]       cy_bx,
    output logic signed [2*COORD_WIDTH+1:0]       by_cx,
    output logic signed [2*COORD_WIDTH+1:0]       cx_sq,
    output logic signed [2*COORD_WIDTH+1:0]       cy_sq,
    output logic [cso_pkg::RSQ_WIDTH-1:0]         rsq
);

    localparam int PW = 2 * COORD_WIDTH + 2;

    logic                            valid_reg;
    logic                            req_reg;
    logic signed [PW-1:0]            ay_bx_reg, by_ax_reg, ay_cx_reg, cy_ax_reg;
    logic signed [PW-1:0]            cy_bx_reg, by_cx_reg, cx_sq_reg, cy_sq_reg;
    logic [cso_pkg::RSQ_WIDTH-1:0]   rsq_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            req_reg   <= in_req;
            ay_bx_reg <= ay * bx;
            by_ax_reg <= by * ax;
            ay_cx_reg <= ay * cx;
            cy_ax_reg <= cy * ax;
            cy_bx_reg <= cy * bx;
            by_cx_reg <= by * cx;
            cx_sq_reg <= cx * cx;
            cy_sq_reg <= cy * cy;
            rsq_reg   <= rsum * rsum;
        end
    end

    assign out_valid = valid_reg;
    assign out_req   = req_reg;
    assign ay_bx     = ay_bx_reg;
    assign by_ax     = by_ax_reg;
    assign ay_cx     = ay_cx_reg;
    assign cy_ax     = cy_ax_reg;
    assign cy_bx     = cy_bx_reg;
    assign by_cx     = by_cx_reg;
    assign cx_sq     = cx_sq_reg;
    assign cy_sq     = cy_sq_reg;
    assign rsq       = rsq_reg;

endmodule

// File: src/cso_sum.sv
`timescale 1ns / 1ps
// Stage 3: determinant, both Cramer numerators and squared centre distance.
// Depends on cso_pkg.
module cso_sum #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_req,
    input  logic signed [2*COORD_WIDTH+1:0]       ay_bx,
    input  logic signed [2*COORD_WIDTH+1:0]       by_ax,
    input  logic signed [2*COORD_WIDTH+1:0]       ay_cx,
    input  logic signed [2*COORD_WIDTH+1:0]       cy_ax,
    input  logic signed [2*COORD_WIDTH+1:0]       cy_bx,
    input  logic signed [2*COORD_WIDTH+1:0]       by_cx,
    input  logic signed [2*COORD_WIDTH+1:0]       cx_sq,
    input  logic signed [2*COORD_WIDTH+1:0]       cy_sq,
    input  logic [cso_pkg::RSQ_WIDTH-1:0]         rsq,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_req,
    output logic signed [2*COORD_WIDTH+2:0]       det,
    output logic signed [2*COORD_WIDTH+2:0]       num1,
    output logic signed [2*COORD_WIDTH+2:0]       num2,
    output logic [2*COORD_WIDTH+2:0]              dist_sq,
    output logic [cso_pkg::RSQ_WIDTH-1:0]         rsq_out
);

    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int SW = PW + 1;

    logic                            valid_reg;
    logic                            req_reg;
    logic signed [SW-1:0]            det_reg, num1_reg, num2_reg;
    logic [SW-1:0]                   dist_sq_reg;
    logic [cso_pkg::RSQ_WIDTH-1:0]   rsq_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // squares are never negative, so the distance sum is taken unsigned
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            req_reg     <= in_req;
            det_reg     <= {ay_bx[PW-1], ay_bx} - {by_ax[PW-1], by_ax};
            num1_reg    <= {ay_cx[PW-1], ay_cx} - {cy_ax[PW-1], cy_ax};
            num2_reg    <= {cy_bx[PW-1], cy_bx} - {by_cx[PW-1], by_cx};
            dist_sq_reg <= {1'b0, cx_sq} + {1'b0, cy_sq};
            rsq_reg     <= rsq;
        end
    end

    assign out_valid = valid_reg;
    assign out_req   = req_reg;
    assign det       = det_reg;
    assign num1      = num1_reg;
    assign num2      = num2_reg;
    assign dist_sq   = dist_sq_reg;
    assign rsq_out   = rsq_reg;

endmodule

// File: src/circle_and_segment_overlap_test.sv
`timescale 1ns / 1ps
// Top level of the circle / segment overlap test: stream ports, decision stage.
// Depends on cso_pkg, cso_diff, cso_mul and cso_sum.
//
// Usage
//   Input words arrive on the s_ channel. s_tuser selects the query: 0 tests
//   two circles (centres p0 and q0, radii radius_a and radius_b), 1 tests the
//   segments p0-p1 and q0-q1. Unused fields of a word are ignored.
//   Each input word yields exactly one result word on the m_ channel, in order:
//   hit in bit 0, parallel in bit 1 (segment determinant is zero; always 0 for
//   circles). Circles that only touch give no hit; a segment end point lying on
//   the other segment does. Parallel or collinear segments never hit.
//   On its way to m_tvalid the word passes four registers: edge vectors
//   (loaded at the accepting edge), products, determinant / numerators /
//   distance, then the sign compares into the output register.
//   Throughput is one word per cycle while m_tready is high; each stage
//   holds its word while the stage after it is full, so a stalled m_tready
//   backs the pipe up one stage at a time and drops s_tready only once all
//   four stages are full. Bubbles are squeezed out while stalled. Nothing is
//   lost or repeated. Reset (aresetn low, synchronous) empties every stage;
//   there is no other state and no configuration.
module circle_and_segment_overlap_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // s_tdata, low bit up: p0_x, p0_y, p1_x, p1_y, q0_x, q0_y, q1_x, q1_y
    // (COORD_WIDTH each), radius_a, radius_b (15 each), zero pad to bytes
    input  logic [((8*COORD_WIDTH+2*cso_pkg::RADIUS_WIDTH+7)/8)*8-1:0] s_tdata,
    // s_tuser: req_type
    input  logic                                           s_tuser,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // m_tdata, low bit up: hit, parallel, zero pad
    output logic [cso_pkg::OUT_TDATA_WIDTH-1:0]            m_tdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * CW + 2;
    localparam int SW   = PW + 1;
    localparam int RW   = cso_pkg::RADIUS_WIDTH;
    localparam int RQW  = cso_pkg::RSQ_WIDTH;
    localparam int CMPW = ((SW > RQW) ? SW : RQW) + 1;
    localparam int RA_LO = 8 * CW;
    localparam int RB_LO = 8 * CW + RW;

    // stage 1 -> 2
    logic                        d_valid, d_ready, d_req;
    logic signed [DW-1:0]        ax, ay, bx, by, cx, cy;
    logic [cso_pkg::RSUM_WIDTH-1:0] rsum;

    // stage 2 -> 3
    logic                        m_valid, m_ready, m_req;
    logic signed [PW-1:0]        ay_bx, by_ax, ay_cx, cy_ax, cy_bx, by_cx, cx_sq, cy_sq;
    logic [RQW-1:0]              rsq;

    // stage 3 -> output
    logic                        s3_valid, s3_ready, s3_req;
    logic signed [SW-1:0]        det, num1, num2;
    logic [SW-1:0]               dist_sq;
    logic [RQW-1:0]              rsq3;

    cso_diff #(.COORD_WIDTH(CW)) u_diff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .p0_x      (s_tdata[0*CW +: CW]),
        .p0_y      (s_tdata[1*CW +: CW]),
        .p1_x      (s_tdata[2*CW +: CW]),
        .p1_y      (s_tdata[3*CW +: CW]),
        .q0_x      (s_tdata[4*CW +: CW]),
        .q0_y      (s_tdata[5*CW +: CW]),
        .q1_x      (s_tdata[6*CW +: CW]),
        .q1_y      (s_tdata[7*CW +: CW]),
        .radius_a  (s_tdata[RA_LO +: RW]),
        .radius_b  (s_tdata[RB_LO +: RW]),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_req   (d_req),
        .ax        (ax),
        .ay        (ay),
        .bx        (bx),
        .by        (by),
        .cx        (cx),
        .cy        (cy),
        .rsum      (rsum)
    );

    cso_mul #(.COORD_WIDTH(CW)) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_req    (d_req),
        .ax        (ax),
        .ay        (ay),
        .bx        (bx),
        .by        (by),
        .cx        (cx),
        .cy        (cy),
        .rsum      (rsum),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_req   (m_req),
        .ay_bx     (ay_bx),
        .by_ax     (by_ax),
        .ay_cx     (ay_cx),
        .cy_ax     (cy_ax),
        .cy_bx     (cy_bx),
        .by_cx     (by_cx),
        .cx_sq     (cx_sq),
        .cy_sq     (cy_sq),
        .rsq       (rsq)
    );

    cso_sum #(.COORD_WIDTH(CW)) u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (m_valid),
        .in_ready  (m_ready),
        .in_req    (m_req),
        .ay_bx     (ay_bx),
        .by_ax     (by_ax),
        .ay_cx     (ay_cx),
        .cy_ax     (cy_ax),
        .cy_bx     (cy_bx),
        .by_cx     (by_cx),
        .cx_sq     (cx_sq),
        .cy_sq     (cy_sq),
        .rsq       (rsq),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_req   (s3_req),
        .det       (det),
        .num1      (num1),
        .num2      (num2),
        .dist_sq   (dist_sq),
        .rsq_out   (rsq3)
    );

    // ---------------- decision stage ----------------
    logic                 out_valid_reg;
    logic                 hit_reg, par_reg;
    logic                 hit_next, par_next;
    logic                 det_zero, n1_ok, n2_ok, circ_hit;
    logic [CMPW-1:0]      dist_ext, rsq_ext;

    assign s3_ready = !out_valid_reg || m_tready;

    assign dist_ext = {{(CMPW-SW){1'b0}}, dist_sq};
    assign rsq_ext  = {{(CMPW-RQW){1'b0}}, rsq3};
    assign circ_hit = dist_ext < rsq_ext;    // strict: touching circles miss
    assign det_zero = (det == '0);

    // 0 <= n/det <= 1 without dividing; the bounds flip for a negative det
    always_comb begin
        if (det[SW-1]) begin
            n1_ok = (num1 <= 0) && (det <= num1);
            n2_ok = (num2 <= 0) && (det <= num2);
        end else begin
            n1_ok = (num1 >= 0) && (num1 <= det);
            n2_ok = (num2 >= 0) && (num2 <= det);
        end
    end

    always_comb begin
        if (s3_req == cso_pkg::REQ_SEGMENT) begin
            par_next = det_zero;
            hit_next = !det_zero && n1_ok && n2_ok;
        end else begin
            par_next = 1'b0;
            hit_next = circ_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_valid && s3_ready) begin
            hit_reg <= hit_next;
            par_reg <= par_next;
        end
    end

    always_comb begin
        m_tdata                   = '0;
        m_tdata[cso_pkg::HIT_BIT] = hit_reg;
        m_tdata[cso_pkg::PAR_BIT] = par_reg;
    end
    assign m_tvalid = out_valid_reg;

    // ---------------- assertions ----------------
    // a parallel pair never reports a hit
    a_par_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[cso_pkg::PAR_BIT] && m_tdata[cso_pkg::HIT_BIT]))
        else $error("parallel result with hit set");

    // an empty output register means the whole pipe can take a word
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // a word waiting behind a stalled output must stay in stage 3
    a_s3_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && s3_valid) |=> s3_valid)
        else $error("stage 3 word lost during output stall");

    // circle results never flag parallel
    a_s3_circle_par: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid && s3_ready && (s3_req == cso_pkg::REQ_CIRCLE))
            |=> !m_tdata[cso_pkg::PAR_BIT])
        else $error("circle query flagged parallel");

endmodule
